// ----- design/bbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared constants, register map and types of the Bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

  // fixed field widths
  localparam int PIX_W   = 24;   // raw sample and color channel width
  localparam int DIM_W   = 13;   // image_width / image_height register width
  localparam int TILE_W  = 2;    // cfa_tile register width

  // defaults of the top-level parameters
  localparam int MAX_WIDTH_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 24;

  // fixed frame limits
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int MIN_DIM    = 3;

  // APB port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CFA_TILE     = 2'd2;

  // register reset values
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd2880;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd1860;

  // color filter phase codes
  localparam logic [TILE_W-1:0] TILE_BG = 2'd0;
  localparam logic [TILE_W-1:0] TILE_GB = 2'd1;
  localparam logic [TILE_W-1:0] TILE_GR = 2'd2;
  localparam logic [TILE_W-1:0] TILE_RG = 2'd3;

  localparam logic [TILE_W-1:0] TILE_RST = TILE_BG;

  // register file view handed to the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [TILE_W-1:0] cfa_tile;
    logic              restart;      // pulse on a write to a mapped register
  } cfg_t;

  // position of the window center within the filter pattern
  typedef struct packed {
    logic [TILE_W-1:0] cfa_tile;
    logic              row_odd;
    logic              col_odd;
  } phase_t;

endpackage

// ----- design/bbd_raw_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_raw_if
// Raw sample channel: one Bayer sample per word.
// ----------------------------------------------------------------------------
interface bbd_raw_if;
  logic                     valid;
  logic                     ready;
  logic [bbd_pkg::PIX_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

// ----- design/bbd_pix_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_pix_if
// Color pixel channel: three channels and an end-of-frame flag per word.
// ----------------------------------------------------------------------------
interface bbd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [bbd_pkg::PIX_W-1:0] first_chroma;
  logic [bbd_pkg::PIX_W-1:0] green_value;
  logic [bbd_pkg::PIX_W-1:0] second_chroma;
  logic                     last_of_frame;

  modport source (output valid, output first_chroma, output green_value,
                  output second_chroma, output last_of_frame, input ready);
  modport sink   (input valid, input first_chroma, input green_value,
                  input second_chroma, input last_of_frame, output ready);
endinterface

// ----- design/bbd_line_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_line_mem
// One-row line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbd_line_mem #(
  parameter int DEPTH = bbd_pkg::MAX_WIDTH_DEF,
  parameter int DW    = bbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bbd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_cfg_regs
// APB register file: geometry and filter phase, restart pulse on write.
// ----------------------------------------------------------------------------
module bbd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbd_pkg::APB_AW-1:0]  paddr,
  input  logic [bbd_pkg::APB_DW-1:0]  pwdata,
  output logic [bbd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output bbd_pkg::cfg_t               cfg_o
);

  logic [bbd_pkg::DIM_W-1:0]  width_q, width_d;
  logic [bbd_pkg::DIM_W-1:0]  height_q, height_d;
  logic [bbd_pkg::TILE_W-1:0] tile_q, tile_d;
  logic                       restart_d;
  logic [1:0]                 idx;
  logic                       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    tile_d    = tile_q;
    restart_d = 1'b0;
    if (wr_en) begin
      case (idx)
        bbd_pkg::REG_IMAGE_WIDTH: begin
          width_d   = pwdata[bbd_pkg::DIM_W-1:0];
          restart_d = 1'b1;
        end
        bbd_pkg::REG_IMAGE_HEIGHT: begin
          height_d  = pwdata[bbd_pkg::DIM_W-1:0];
          restart_d = 1'b1;
        end
        bbd_pkg::REG_CFA_TILE: begin
          tile_d    = pwdata[bbd_pkg::TILE_W-1:0];
          restart_d = 1'b1;
        end
        default: begin
          restart_d = 1'b0;  // unmapped: ignored
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      bbd_pkg::REG_IMAGE_WIDTH:  prdata = bbd_pkg::APB_DW'(width_q);
      bbd_pkg::REG_IMAGE_HEIGHT: prdata = bbd_pkg::APB_DW'(height_q);
      bbd_pkg::REG_CFA_TILE:     prdata = bbd_pkg::APB_DW'(tile_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= bbd_pkg::WIDTH_RST;
      height_q  <= bbd_pkg::HEIGHT_RST;
      tile_q    <= bbd_pkg::TILE_RST;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      tile_q    <= tile_d;
    end
  end

  // restart is a combinational pulse so the counters clear at the write edge
  assign cfg_o.image_width  = width_q;
  assign cfg_o.image_height = height_q;
  assign cfg_o.cfa_tile     = tile_q;
  assign cfg_o.restart      = restart_d;

endmodule

// ----- design/bbd_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear interpolation of one 3x3 window into three color channels.
// ----------------------------------------------------------------------------
module bbd_interp #(
  parameter int DW = bbd_pkg::SAMPLE_BITS_DEF
) (
  input  bbd_pkg::phase_t phase_i,
  input  logic [DW-1:0]   tl_i,
  input  logic [DW-1:0]   tm_i,
  input  logic [DW-1:0]   tr_i,
  input  logic [DW-1:0]   ml_i,
  input  logic [DW-1:0]   ctr_i,
  input  logic [DW-1:0]   mr_i,
  input  logic [DW-1:0]   bl_i,
  input  logic [DW-1:0]   bm_i,
  input  logic [DW-1:0]   br_i,
  output logic [DW-1:0]   ch0_o,
  output logic [DW-1:0]   ch1_o,
  output logic [DW-1:0]   ch2_o
);

  logic          g0, b0, side, green;
  logic [DW:0]   vert_s, horiz_s;
  logic [DW+1:0] diag_s, orth_s;
  logic [DW-1:0] vert, horiz, diag, orth;

  assign g0    = phase_i.cfa_tile inside {bbd_pkg::TILE_GB, bbd_pkg::TILE_GR};
  assign b0    = phase_i.cfa_tile inside {bbd_pkg::TILE_GR, bbd_pkg::TILE_RG};
  assign side  = b0 ^ phase_i.row_odd;
  assign green = phase_i.col_odd ^ g0 ^ phase_i.row_odd;

  // rounded means
  assign vert_s  = (DW+1)'(tm_i) + (DW+1)'(bm_i) + (DW+1)'(1);
  assign horiz_s = (DW+1)'(ml_i) + (DW+1)'(mr_i) + (DW+1)'(1);
  assign diag_s  = (DW+2)'(tl_i) + (DW+2)'(tr_i) + (DW+2)'(bl_i) + (DW+2)'(br_i)
                 + (DW+2)'(2);
  assign orth_s  = (DW+2)'(tm_i) + (DW+2)'(ml_i) + (DW+2)'(mr_i) + (DW+2)'(bm_i)
                 + (DW+2)'(2);

  assign vert  = vert_s[DW:1];
  assign horiz = horiz_s[DW:1];
  assign diag  = diag_s[DW+1:2];
  assign orth  = orth_s[DW+1:2];

  always_comb begin
    if (green) begin
      ch1_o = ctr_i;
      ch0_o = side ? vert : horiz;
      ch2_o = side ? horiz : vert;
    end else begin
      ch1_o = orth;
      ch0_o = side ? diag : ctr_i;
      ch2_o = side ? ctr_i : diag;
    end
  end

endmodule

// ----- design/bayer_bilinear_demosaic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic: raw Bayer samples in, one RGB word out per
// interior position, built around two single-port-per-direction line stores.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      word
//  --------  ---  -------------  ------------------------------------------
//  raw_in    in   valid/ready    raw_sample
//  pix_out   out  valid/ready    first_chroma, green_value, second_chroma,
//                                last_of_frame
//  apb       in   psel/penable   image_width, image_height, cfa_tile
//
//  Throughput is one raw word per cycle while the output is not held. A pixel
//  leaves after the raw word that completes its window, through the line-store
//  read register and then the output register.
//  Reset clears the counters, the window and the pipeline valids; the line
//  stores are not cleared and only reach a pixel after the first two rows.
//  A held output stalls the sample in the read stage (and with it the input)
//  only if that sample makes a pixel; border samples drain regardless.
//  Any write to a mapped register restarts the frame at row 0, column 0.
//
module bayer_bilinear_demosaic #(
  parameter int MAX_WIDTH   = bbd_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = bbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbd_pkg::APB_AW-1:0] paddr,
  input  logic [bbd_pkg::APB_DW-1:0] pwdata,
  output logic [bbd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  bbd_raw_if.sink                    raw_in,
  bbd_pix_if.source                  pix_out
);

  // sample width actually kept (port is fixed at PIX_W)
  localparam int DW   = (SAMPLE_BITS < bbd_pkg::PIX_W) ? SAMPLE_BITS : bbd_pkg::PIX_W;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCW  = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WCW > bbd_pkg::DIM_W) ? WCW : bbd_pkg::DIM_W;
  localparam int RW   = bbd_pkg::ROW_W;

  bbd_pkg::cfg_t cfg;

  bbd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // Effective geometry, clamped to the supported range
  // --------------------------------------------------------------------------
  logic [CMPW-1:0]          w_reg, w_eff, w_last;
  logic [bbd_pkg::DIM_W-1:0] h_eff, h_last;

  assign w_reg = CMPW'(cfg.image_width);

  always_comb begin
    if (w_reg < CMPW'(bbd_pkg::MIN_DIM)) begin
      w_eff = CMPW'(bbd_pkg::MIN_DIM);
    end else if (w_reg > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_reg;
    end
    if (cfg.image_height < bbd_pkg::DIM_W'(bbd_pkg::MIN_DIM)) begin
      h_eff = bbd_pkg::DIM_W'(bbd_pkg::MIN_DIM);
    end else if (cfg.image_height > bbd_pkg::DIM_W'(bbd_pkg::MAX_HEIGHT)) begin
      h_eff = bbd_pkg::DIM_W'(bbd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg.image_height;
    end
  end

  assign w_last = w_eff - CMPW'(1);
  assign h_last = h_eff - bbd_pkg::DIM_W'(1);

  // --------------------------------------------------------------------------
  // Handshake and stage control
  //   accept : raw word taken, line stores read at the current column
  //   adv    : read stage retires, line stores written, window shifts
  // --------------------------------------------------------------------------
  logic accept, adv;
  logic a_valid_q, a_valid_d;
  logic o_valid_q, o_valid_d;
  logic a_prod_q, a_last_q, a_row_odd_q, a_col_odd_q;
  logic [CW-1:0] a_col_q;
  logic [DW-1:0] a_raw_q;

  assign adv    = a_valid_q & (~a_prod_q | ~o_valid_q | pix_out.ready);
  assign raw_in.ready = ~a_valid_q | adv;
  assign accept = raw_in.valid & raw_in.ready;

  // --------------------------------------------------------------------------
  // Frame position of the next raw word
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          col_end, row_end;

  assign col_end = (CMPW'(col_q) == w_last);
  assign row_end = (bbd_pkg::DIM_W'(row_q) == h_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores. Read at accept, write back at retire. The word being written
  // and the word being read are always in different columns (width >= 3),
  // and a column is rewritten at least two words before it is read again,
  // so no forwarding is needed.
  // --------------------------------------------------------------------------
  logic [DW-1:0] up2, up1;

  bbd_line_mem #(.DEPTH(MAX_WIDTH), .DW(DW)) u_older (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (a_col_q),
    .wdata_i (up1),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up2)
  );

  bbd_line_mem #(.DEPTH(MAX_WIDTH), .DW(DW)) u_newer (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (a_col_q),
    .wdata_i (a_raw_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (up1)
  );

  // --------------------------------------------------------------------------
  // Read stage: carries the raw word and its position alongside the read
  // --------------------------------------------------------------------------
  always_comb begin
    a_valid_d = a_valid_q;
    if (cfg.restart) begin
      a_valid_d = 1'b0;
    end else if (accept) begin
      a_valid_d = 1'b1;
    end else if (adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_raw_q     <= raw_in.raw_sample[DW-1:0];
      a_col_q     <= col_q;
      a_col_odd_q <= col_q[0];
      a_row_odd_q <= row_q[0];               // parity of r-2 equals parity of r
      a_prod_q    <= (row_q >= RW'(2)) && (col_q >= CW'(2));
      a_last_q    <= row_end & col_end;
    end
  end

  // --------------------------------------------------------------------------
  // 3x3 window: left and middle columns in flops, right column from the
  // line-store read data and the raw word
  //   [0] tl [1] ml [2] bl  [3] tm [4] ctr [5] bm
  // --------------------------------------------------------------------------
  logic [DW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cfg.restart) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= up2;
      win_q[4] <= up1;
      win_q[5] <= a_raw_q;
    end
  end

  bbd_pkg::phase_t phase;
  logic [DW-1:0]   ch0, ch1, ch2;

  assign phase.cfa_tile = cfg.cfa_tile;
  assign phase.row_odd  = a_row_odd_q;
  assign phase.col_odd  = a_col_odd_q;

  bbd_interp #(.DW(DW)) u_interp (
    .phase_i (phase),
    .tl_i    (win_q[0]),
    .tm_i    (win_q[3]),
    .tr_i    (up2),
    .ml_i    (win_q[1]),
    .ctr_i   (win_q[4]),
    .mr_i    (up1),
    .bl_i    (win_q[2]),
    .bm_i    (win_q[5]),
    .br_i    (a_raw_q),
    .ch0_o   (ch0),
    .ch1_o   (ch1),
    .ch2_o   (ch2)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [bbd_pkg::PIX_W-1:0] ch0_q, ch1_q, ch2_q;
  logic                      last_q;

  always_comb begin
    o_valid_d = o_valid_q;
    if (adv && a_prod_q) begin
      o_valid_d = 1'b1;
    end else if (pix_out.ready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_prod_q) begin
      ch0_q  <= bbd_pkg::PIX_W'(ch0);
      ch1_q  <= bbd_pkg::PIX_W'(ch1);
      ch2_q  <= bbd_pkg::PIX_W'(ch2);
      last_q <= a_last_q;
    end
  end

  assign pix_out.valid         = o_valid_q;
  assign pix_out.first_chroma  = ch0_q;
  assign pix_out.green_value   = ch1_q;
  assign pix_out.second_chroma = ch2_q;
  assign pix_out.last_of_frame = last_q;

endmodule

// ----- tb/bayer_bilinear_demosaic_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_test
// Self-checking bench for the streaming Bayer demosaic. Raw words go in
// through a bursty sender and pixel words come out into a sink that stalls
// on its own pattern. A local predictor keeps its own line stores, window
// and frame position and works out every pixel word, which is checked in
// order. Runs power-on geometry, a short directed table, the largest frames
// and then randomized geometry, filter phase and content.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_test;

  localparam int          LINE_DEPTH     = bbd_pkg::MAX_WIDTH_DEF;
  localparam int          PIPE_SETTLE    = 8;
  localparam int          POWER_ON_ITEMS = 20;
  localparam int          WIDE_ITEMS     = 20;
  localparam int          TALL_ROWS      = 40;
  localparam int          RANDOM_ITEMS   = 560;
  localparam logic [1:0]  REG_BAD        = 2'd3;  // no register lives here

  typedef struct packed {
    logic [bbd_pkg::PIX_W-1:0] first_chroma;
    logic [bbd_pkg::PIX_W-1:0] green_value;
    logic [bbd_pkg::PIX_W-1:0] second_chroma;
    logic                      last_of_frame;
  } pixel_t;

  typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_e;

  // one row of the directed table; sample rows carry REG_BAD as a filler
  typedef struct packed {
    step_kind_e  kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        typed;   // want holds a hand-computed pixel
    pixel_t      want;
  } step_t;

  typedef enum logic [1:0] {SINK_FREE, SINK_CHOPPY, SINK_STARVED} sink_mode_e;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bbd_pkg::APB_AW-1:0]  paddr;
  logic [bbd_pkg::APB_DW-1:0]  pwdata;
  logic [bbd_pkg::APB_DW-1:0]  prdata;
  logic                        pready;

  bbd_raw_if raw_if ();
  bbd_pix_if pix_if ();

  bayer_bilinear_demosaic u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .raw_in  (raw_if),
    .pix_out (pix_if)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // predictor state: registers, line stores, window, frame position
  // --------------------------------------------------------------------------
  logic [bbd_pkg::DIM_W-1:0]  cfg_width;
  logic [bbd_pkg::DIM_W-1:0]  cfg_height;
  logic [bbd_pkg::TILE_W-1:0] cfg_tile;
  bit [bbd_pkg::PIX_W-1:0]    older_line [LINE_DEPTH];
  bit [bbd_pkg::PIX_W-1:0]    newer_line [LINE_DEPTH];
  bit [bbd_pkg::PIX_W-1:0]    win [6];   // tl ml bl tm ctr bm
  int unsigned                col_pos;
  int unsigned                row_pos;

  pixel_t      pending_pixels [$];
  int unsigned mismatches = 0;
  int unsigned pixels_seen = 0;
  int unsigned burst_left;

  function automatic int unsigned clamp_dim(logic [bbd_pkg::DIM_W-1:0] v, int unsigned hi);
    if (v < bbd_pkg::MIN_DIM) return bbd_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_frame_position();
    col_pos = 0;
    row_pos = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  // register write as the block sees it; unused index leaves the frame alone
  function automatic void latch_register(logic [1:0] idx, logic [31:0] data);
    case (idx)
      bbd_pkg::REG_IMAGE_WIDTH:  cfg_width  = data[bbd_pkg::DIM_W-1:0];
      bbd_pkg::REG_IMAGE_HEIGHT: cfg_height = data[bbd_pkg::DIM_W-1:0];
      bbd_pkg::REG_CFA_TILE:     cfg_tile   = data[bbd_pkg::TILE_W-1:0];
      default:                   return;
    endcase
    clear_frame_position();
  endfunction

  // one raw word in; returns 1 with the pixel when it closes an interior window
  function automatic bit demosaic_step(input logic [bbd_pkg::PIX_W-1:0] raw,
                                       output pixel_t px);
    int unsigned               w;
    int unsigned               h;
    logic [bbd_pkg::PIX_W-1:0] up2;
    logic [bbd_pkg::PIX_W-1:0] up1;
    logic [bbd_pkg::PIX_W-1:0] vert;
    logic [bbd_pkg::PIX_W-1:0] horiz;
    logic [bbd_pkg::PIX_W-1:0] diag;
    logic [bbd_pkg::PIX_W-1:0] orth;
    logic [bbd_pkg::PIX_W:0]   pair_sum;
    logic [bbd_pkg::PIX_W+1:0] quad_sum;
    bit                        g0;
    bit                        b0;
    bit                        side;
    bit                        green;
    bit                        made;
    w = clamp_dim(cfg_width, LINE_DEPTH);
    h = clamp_dim(cfg_height, bbd_pkg::MAX_HEIGHT);
    up2 = older_line[col_pos];
    up1 = newer_line[col_pos];
    made = (row_pos >= 2) && (col_pos >= 2);
    px = '0;
    if (made) begin
      g0 = (cfg_tile == bbd_pkg::TILE_GB) || (cfg_tile == bbd_pkg::TILE_GR);
      b0 = (cfg_tile == bbd_pkg::TILE_GR) || (cfg_tile == bbd_pkg::TILE_RG);
      // top row of the window has the parity of the current row
      side  = b0 ^ row_pos[0];
      green = col_pos[0] ^ g0 ^ row_pos[0];
      pair_sum = (bbd_pkg::PIX_W+1)'(win[3]) + (bbd_pkg::PIX_W+1)'(win[5]) + 1'b1;
      vert     = pair_sum[bbd_pkg::PIX_W:1];
      pair_sum = (bbd_pkg::PIX_W+1)'(win[1]) + (bbd_pkg::PIX_W+1)'(up1) + 1'b1;
      horiz    = pair_sum[bbd_pkg::PIX_W:1];
      quad_sum = (bbd_pkg::PIX_W+2)'(win[0]) + (bbd_pkg::PIX_W+2)'(up2)
               + (bbd_pkg::PIX_W+2)'(win[2]) + (bbd_pkg::PIX_W+2)'(raw) + 2'd2;
      diag     = quad_sum[bbd_pkg::PIX_W+1:2];
      quad_sum = (bbd_pkg::PIX_W+2)'(win[3]) + (bbd_pkg::PIX_W+2)'(win[1])
               + (bbd_pkg::PIX_W+2)'(up1) + (bbd_pkg::PIX_W+2)'(win[5]) + 2'd2;
      orth     = quad_sum[bbd_pkg::PIX_W+1:2];
      if (green) begin
        px.green_value   = win[4];
        px.first_chroma  = side ? vert : horiz;
        px.second_chroma = side ? horiz : vert;
      end else begin
        px.green_value   = orth;
        px.first_chroma  = side ? diag : win[4];
        px.second_chroma = side ? win[4] : diag;
      end
      px.last_of_frame = (row_pos == h - 1) && (col_pos == w - 1);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up2;
    win[4] = up1;
    win[5] = raw;
    older_line[col_pos] = up1;
    newer_line[col_pos] = raw;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return made;
  endfunction

  function automatic logic [bbd_pkg::PIX_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return bbd_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // raw word sender: bursts of random length, idle gaps between
  // --------------------------------------------------------------------------
  task automatic push_sample(input logic [bbd_pkg::PIX_W-1:0] raw, input bit typed,
                             input pixel_t typed_px);
    pixel_t px;
    bit     made;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                               : $urandom_range(1, 12);
    end
    raw_if.valid      <= 1'b1;
    raw_if.raw_sample <= raw;
    do @(posedge clk_i); while (!raw_if.ready);
    burst_left--;
    if (burst_left == 0) raw_if.valid <= 1'b0;
    made = demosaic_step(raw, px);
    if (typed) pending_pixels.push_back(typed_px);
    else if (made) pending_pixels.push_back(px);
  endtask

  // drop valid in this step unless the last push already did
  task automatic park_sender();
    if (burst_left != 0) raw_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  // sender holds off until every predicted pixel is out and the pipe is empty
  task automatic wait_pixels_out();
    park_sender();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    wait_pixels_out();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    latch_register(idx, data);
  endtask

  // --------------------------------------------------------------------------
  // pixel sink: ready pattern switches between free, choppy and starved
  // --------------------------------------------------------------------------
  sink_mode_e  sink_mode;
  int unsigned sink_left = 0;

  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      sink_left = $urandom_range(1, 64);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_FREE:    pix_if.ready <= 1'b1;
      SINK_CHOPPY:  pix_if.ready <= 1'($urandom_range(0, 1));
      default:      pix_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // in-order check of every accepted pixel word
  pixel_t seen_px;
  pixel_t want_px;

  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      seen_px = '{pix_if.first_chroma, pix_if.green_value, pix_if.second_chroma,
                  pix_if.last_of_frame};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel %0d: none predicted, got ch0 %h g %h ch2 %h last %b",
                   pixels_seen, seen_px.first_chroma, seen_px.green_value,
                   seen_px.second_chroma, seen_px.last_of_frame);
      end else begin
        want_px = pending_pixels.pop_front();
        if (seen_px !== want_px) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %0d: want ch0 %h g %h ch2 %h last %b, got ch0 %h g %h ch2 %h last %b",
                     pixels_seen, want_px.first_chroma, want_px.green_value,
                     want_px.second_chroma, want_px.last_of_frame, seen_px.first_chroma,
                     seen_px.green_value, seen_px.second_chroma, seen_px.last_of_frame);
        end
      end
      pixels_seen++;
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("bayer_bilinear_demosaic regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    step_t                      plan [$];
    step_t                      row;
    logic [bbd_pkg::DIM_W-1:0]  w_reg;
    logic [bbd_pkg::DIM_W-1:0]  h_reg;
    logic [bbd_pkg::TILE_W-1:0] t_reg;
    int unsigned                w_eff;
    int unsigned                h_eff;
    int unsigned                n_items;
    int unsigned                random_items;

    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    raw_if.valid      <= 1'b0;
    raw_if.raw_sample <= '0;
    burst_left   = 0;
    random_items = 0;
    cfg_width    = bbd_pkg::WIDTH_RST;
    cfg_height   = bbd_pkg::HEIGHT_RST;
    cfg_tile     = bbd_pkg::TILE_RST;
    clear_frame_position();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-on geometry: part of the first row, no pixel may come out
    repeat (POWER_ON_ITEMS) push_sample(rand_sample(), 1'b0, '0);

    // directed table
    plan.push_back('{STEP_WRITE, bbd_pkg::REG_IMAGE_WIDTH, 32'd3, 1'b0, '0});
    plan.push_back('{STEP_WRITE, bbd_pkg::REG_IMAGE_HEIGHT, 32'd3, 1'b0, '0});
    plan.push_back('{STEP_WRITE, bbd_pkg::REG_CFA_TILE, 32'(bbd_pkg::TILE_BG), 1'b0, '0});
    // 3x3 frame at full scale: every mean rounds back to full scale
    for (int i = 0; i < 8; i++)
      plan.push_back('{STEP_SAMPLE, REG_BAD, 32'hFF_FFFF, 1'b0, '0});
    plan.push_back('{STEP_SAMPLE, REG_BAD, 32'hFF_FFFF, 1'b1,
                     '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1}});
    // all-zero frame after wrap, with a write to the unused index mid-frame
    for (int i = 0; i < 4; i++)
      plan.push_back('{STEP_SAMPLE, REG_BAD, 32'h0, 1'b0, '0});
    plan.push_back('{STEP_WRITE, REG_BAD, 32'hFFFF_FFFF, 1'b0, '0});
    for (int i = 0; i < 4; i++)
      plan.push_back('{STEP_SAMPLE, REG_BAD, 32'h0, 1'b0, '0});
    plan.push_back('{STEP_SAMPLE, REG_BAD, 32'h0, 1'b1, '{24'h0, 24'h0, 24'h0, 1'b1}});
    // partial frame cut short by writes; upper data bits are dropped and
    // undersized geometry saturates to 3
    for (int i = 0; i < 3; i++)
      plan.push_back('{STEP_SAMPLE, REG_BAD, 32'hAB_CDEF, 1'b0, '0});
    plan.push_back('{STEP_WRITE, bbd_pkg::REG_IMAGE_WIDTH, 32'hFFFF_E000, 1'b0, '0});
    plan.push_back('{STEP_WRITE, bbd_pkg::REG_IMAGE_HEIGHT, 32'hFFFF_E002, 1'b0, '0});
    plan.push_back('{STEP_WRITE, bbd_pkg::REG_CFA_TILE,
                     32'hFFFF_FFFC | 32'(bbd_pkg::TILE_GB), 1'b0, '0});
    // green-centered checkerboard
    for (int i = 0; i < 9; i++)
      plan.push_back('{STEP_SAMPLE, REG_BAD, (i % 2 == 0) ? 32'hFF_FFFF : 32'h00_0001,
                       1'b0, '0});

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == STEP_WRITE) write_register(row.reg_idx, row.value);
      else push_sample(row.value[bbd_pkg::PIX_W-1:0], row.typed, row.want);
    end

    // widest line (oversized value saturates), shortest frame: first row only
    write_register(bbd_pkg::REG_IMAGE_WIDTH, 32'h0000_1FFF);
    write_register(bbd_pkg::REG_IMAGE_HEIGHT, 32'd3);
    write_register(bbd_pkg::REG_CFA_TILE, 32'(bbd_pkg::TILE_RG));
    repeat (WIDE_ITEMS) push_sample(rand_sample(), 1'b0, '0);

    // tallest frame on the narrowest line, first rows of it
    write_register(bbd_pkg::REG_IMAGE_WIDTH, 32'd2);
    write_register(bbd_pkg::REG_IMAGE_HEIGHT, 32'(bbd_pkg::MAX_HEIGHT));
    write_register(bbd_pkg::REG_CFA_TILE, 32'(bbd_pkg::TILE_GR));
    repeat (3 * TALL_ROWS) push_sample(rand_sample(), 1'b0, '0);

    // random geometry, phase and content; mostly small frames, between one
    // and two full frames' worth of samples per setting
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_reg = bbd_pkg::DIM_W'($urandom_range(0, 2));
        1:       w_reg = bbd_pkg::DIM_W'($urandom_range(13, 32));
        default: w_reg = bbd_pkg::DIM_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h_reg = bbd_pkg::DIM_W'($urandom_range(0, 2));
        1:       h_reg = bbd_pkg::DIM_W'($urandom_range(9, 12));
        default: h_reg = bbd_pkg::DIM_W'($urandom_range(3, 8));
      endcase
      t_reg = bbd_pkg::TILE_W'($urandom_range(0, 3));
      // the tall frame above must not carry into the random part
      if (random_items == 0 || $urandom_range(0, 3) != 0)
        write_register(bbd_pkg::REG_IMAGE_WIDTH, ($urandom & ~32'h1FFF) | 32'(w_reg));
      if (random_items == 0 || $urandom_range(0, 3) != 0)
        write_register(bbd_pkg::REG_IMAGE_HEIGHT, ($urandom & ~32'h1FFF) | 32'(h_reg));
      if ($urandom_range(0, 3) != 0)
        write_register(bbd_pkg::REG_CFA_TILE, ($urandom & ~32'h3) | 32'(t_reg));
      if ($urandom_range(0, 7) == 0)
        write_register(REG_BAD, $urandom);
      w_eff   = clamp_dim(cfg_width, LINE_DEPTH);
      h_eff   = clamp_dim(cfg_height, bbd_pkg::MAX_HEIGHT);
      n_items = $urandom_range(w_eff * h_eff, 2 * w_eff * h_eff);
      if (n_items > RANDOM_ITEMS - random_items) n_items = RANDOM_ITEMS - random_items;
      repeat (n_items) begin
        if ($urandom_range(0, 99) == 0) wait_pixels_out();
        push_sample(rand_sample(), 1'b0, '0);
      end
      random_items += n_items;
    end

    wait_pixels_out();
    if (mismatches == 0 && pending_pixels.size() == 0)
      $display("bayer_bilinear_demosaic regression: pass");
    else
      $display("bayer_bilinear_demosaic regression: fail");
    $finish;
  end

endmodule
